[rtl/spsc_pkg.sv]
// Package for the serial port shift controller: beat kinds, register offsets,
// control bit positions and reset values. No dependencies.
`timescale 1ns / 1ps

package spsc_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  localparam logic [3:0] ADDR_DATA    = 4'h0;
  localparam logic [3:0] ADDR_STATUS  = 4'h4;
  localparam logic [3:0] ADDR_MODE    = 4'h8;
  localparam logic [3:0] ADDR_CONTROL = 4'hA;
  localparam logic [3:0] ADDR_BAUD    = 4'hE;

  localparam int unsigned CTL_TX_EN    = 0;
  localparam int unsigned CTL_DTR      = 1;
  localparam int unsigned CTL_RX_EN    = 2;
  localparam int unsigned CTL_ACK      = 4;
  localparam int unsigned CTL_RESET    = 6;
  localparam int unsigned CTL_LEN_LO   = 8;
  localparam int unsigned CTL_LEN_HI   = 9;
  localparam int unsigned CTL_TX_IRQ   = 10;
  localparam int unsigned CTL_RX_IRQ   = 11;
  localparam int unsigned CTL_DSR_IRQ  = 12;
  localparam int unsigned CTL_PORT_SEL = 13;

  localparam logic [15:0] CTL_STORE_MASK = 16'hFFAF;
  localparam logic [7:0]  PERIOD_RESET   = 8'h88;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  addr;
    logic [31:0] wdata;
    logic        rxd;
    logic        dsr;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        txd;
    logic        strobe;
    logic        dtr0;
    logic        dtr1;
    logic        irq;
  } out_beat_t;

endpackage

[rtl/serial_port_shift_controller.sv]
// Serial port shift controller: register file, bit divider, transmit and
// receive shifters, interrupt logic. Depends on spsc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): one beat is a bus write, a bus read,
//   one clock tick carrying the sampled receive and DSR lines, or a no-op.
//   Result channel (out_valid/out_ready): exactly one result beat per input
//   beat, in order: read data, transmit bit, bit strobe, DTR levels and the
//   interrupt level after the beat.
//   Configuration: cfg_we writes cfg_wdata into the bit period at once.
//   Throughput: one beat per cycle while out_ready is high; the single pass
//   from the input register through the register update logic into the
//   result register sets it. A taken beat waits in the input register and
//   its result in the result register.
//   Reset: all port state, the interrupt and the divider clear, the bit
//   period returns to 136, and no beat is held in either register.
//   Stall: while a result waits and out_ready is low, the result register
//   holds, and an input beat held behind it keeps in_ready low.
module serial_port_shift_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_addr,
  input  logic [31:0] in_wdata,
  input  logic        in_rxd_in,
  input  logic        in_dsr_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rdata,
  output logic        out_txd_out,
  output logic        out_bit_strobe,
  output logic        out_dtr_port0,
  output logic        out_dtr_port1,
  output logic        out_irq_level,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  spsc_pkg::in_beat_t  stage_r;
  logic                stage_v_r;
  spsc_pkg::out_beat_t res_r, res_nxt;
  logic                out_v_r;
  logic                advance;

  logic [7:0]  period_r;
  logic [31:0] tx_shift_r, tx_shift_nxt;
  logic [31:0] rx_shift_r, rx_shift_nxt;
  logic [4:0]  tx_count_r, tx_count_nxt;
  logic [4:0]  rx_count_r, rx_count_nxt;
  logic        tx_busy_r, tx_busy_nxt;
  logic        rx_busy_r, rx_busy_nxt;
  logic        rx_ready_r, rx_ready_nxt;
  logic [15:0] control_r, control_nxt;
  logic [15:0] mode_r, mode_nxt;
  logic [15:0] baud_r, baud_nxt;
  logic        dsr_prev_r, dsr_prev_nxt;
  logic [7:0]  div_r, div_nxt;
  logic        irq_r, irq_nxt;

  logic [5:0]  word_len;
  logic        tx_done, rx_done, step_go;
  logic [8:0]  div_sum;

  assign advance  = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || advance;

  assign word_len = {1'b0, control_r[spsc_pkg::CTL_LEN_HI:spsc_pkg::CTL_LEN_LO], 3'b000}
                    + 6'd8;
  assign tx_done  = ({1'b0, tx_count_r} + 6'd1) >= word_len;
  assign rx_done  = ({1'b0, rx_count_r} + 6'd1) >= word_len;
  assign step_go  = (rx_busy_r && control_r[spsc_pkg::CTL_RX_EN]) ||
                    (tx_busy_r && control_r[spsc_pkg::CTL_TX_EN]);
  assign div_sum  = {1'b0, div_r} + {1'b0, period_r};

  always_comb begin
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;
    tx_count_nxt = tx_count_r;
    rx_count_nxt = rx_count_r;
    tx_busy_nxt  = tx_busy_r;
    rx_busy_nxt  = rx_busy_r;
    rx_ready_nxt = rx_ready_r;
    control_nxt  = control_r;
    mode_nxt     = mode_r;
    baud_nxt     = baud_r;
    dsr_prev_nxt = dsr_prev_r;
    div_nxt      = div_r;
    irq_nxt      = irq_r;
    res_nxt      = '0;

    unique case (stage_r.kind)
      spsc_pkg::KIND_WRITE: begin
        unique case (stage_r.addr)
          spsc_pkg::ADDR_DATA: begin
            tx_shift_nxt = stage_r.wdata;
            tx_busy_nxt  = 1'b1;
          end
          spsc_pkg::ADDR_MODE: mode_nxt = stage_r.wdata[15:0];
          spsc_pkg::ADDR_CONTROL: begin
            control_nxt = stage_r.wdata[15:0] & spsc_pkg::CTL_STORE_MASK;
            if (stage_r.wdata[spsc_pkg::CTL_ACK]) begin
              irq_nxt = 1'b0;
            end
            if (stage_r.wdata[spsc_pkg::CTL_RESET]) begin
              irq_nxt      = 1'b0;
              rx_busy_nxt  = 1'b0;
              tx_busy_nxt  = 1'b0;
              rx_ready_nxt = 1'b0;
              tx_shift_nxt = '0;
              rx_shift_nxt = '0;
              rx_count_nxt = '0;
              tx_count_nxt = '0;
              mode_nxt     = '0;
              control_nxt  = '0;
              baud_nxt     = '0;
            end
          end
          spsc_pkg::ADDR_BAUD: baud_nxt = stage_r.wdata[15:0];
          default: ;
        endcase
      end
      spsc_pkg::KIND_READ: begin
        unique case (stage_r.addr)
          spsc_pkg::ADDR_DATA: begin
            res_nxt.rdata = rx_shift_r;
            rx_ready_nxt  = 1'b0;
            rx_busy_nxt   = 1'b1;
          end
          spsc_pkg::ADDR_STATUS:  res_nxt.rdata = {30'd0, rx_ready_r, !tx_busy_r};
          spsc_pkg::ADDR_MODE:    res_nxt.rdata = {16'd0, mode_r};
          spsc_pkg::ADDR_CONTROL: res_nxt.rdata = {16'd0, control_r};
          spsc_pkg::ADDR_BAUD:    res_nxt.rdata = {16'd0, baud_r};
          default: ;
        endcase
      end
      spsc_pkg::KIND_TICK: begin
        if (div_r <= 8'd1) begin
          div_nxt        = (div_sum == 9'd0) ? 8'd0 : 8'(div_sum - 9'd1);
          res_nxt.strobe = 1'b1;
          if (step_go) begin
            if (tx_busy_r) begin
              res_nxt.txd = tx_shift_r[tx_count_r];
              if (tx_done) begin
                tx_count_nxt = '0;
                tx_busy_nxt  = 1'b0;
                if (control_r[spsc_pkg::CTL_TX_IRQ]) begin
                  irq_nxt = 1'b1;
                end
              end else begin
                tx_count_nxt = tx_count_r + 5'd1;
              end
            end
            if (rx_busy_r) begin
              rx_shift_nxt[rx_count_r] = stage_r.rxd;
              if (rx_done) begin
                rx_count_nxt = '0;
                rx_busy_nxt  = 1'b0;
                rx_ready_nxt = 1'b1;
                if (control_r[spsc_pkg::CTL_RX_IRQ]) begin
                  irq_nxt = 1'b1;
                end
              end else begin
                rx_count_nxt = rx_count_r + 5'd1;
              end
            end
          end
        end else begin
          div_nxt = div_r - 8'd1;
        end
        if (stage_r.dsr && !dsr_prev_r && control_r[spsc_pkg::CTL_DSR_IRQ]) begin
          irq_nxt = 1'b1;
        end
        dsr_prev_nxt = stage_r.dsr;
      end
      spsc_pkg::KIND_NOP: ;
    endcase

    res_nxt.dtr0 = control_nxt[spsc_pkg::CTL_DTR] && !control_nxt[spsc_pkg::CTL_PORT_SEL];
    res_nxt.dtr1 = control_nxt[spsc_pkg::CTL_DTR] && control_nxt[spsc_pkg::CTL_PORT_SEL];
    res_nxt.irq  = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= spsc_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r  <= 1'b0;
      out_v_r    <= 1'b0;
      tx_shift_r <= '0;
      rx_shift_r <= '0;
      tx_count_r <= '0;
      rx_count_r <= '0;
      tx_busy_r  <= 1'b0;
      rx_busy_r  <= 1'b0;
      rx_ready_r <= 1'b0;
      control_r  <= '0;
      mode_r     <= '0;
      baud_r     <= '0;
      dsr_prev_r <= 1'b0;
      div_r      <= '0;
      irq_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        tx_shift_r <= tx_shift_nxt;
        rx_shift_r <= rx_shift_nxt;
        tx_count_r <= tx_count_nxt;
        rx_count_r <= rx_count_nxt;
        tx_busy_r  <= tx_busy_nxt;
        rx_busy_r  <= rx_busy_nxt;
        rx_ready_r <= rx_ready_nxt;
        control_r  <= control_nxt;
        mode_r     <= mode_nxt;
        baud_r     <= baud_nxt;
        dsr_prev_r <= dsr_prev_nxt;
        div_r      <= div_nxt;
        irq_r      <= irq_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.kind  <= spsc_pkg::kind_t'(in_mode);
      stage_r.addr  <= in_addr;
      stage_r.wdata <= in_wdata;
      stage_r.rxd   <= in_rxd_in;
      stage_r.dsr   <= in_dsr_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_rdata      = res_r.rdata;
  assign out_txd_out    = res_r.txd;
  assign out_bit_strobe = res_r.strobe;
  assign out_dtr_port0  = res_r.dtr0;
  assign out_dtr_port1  = res_r.dtr1;
  assign out_irq_level  = res_r.irq;

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !advance |=> stage_v_r)
    else $error("input beat dropped while blocked");

  a_tx_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_busy_r |-> tx_count_r == 5'd0)
    else $error("transmit count nonzero while idle");

  a_rx_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !rx_busy_r |-> rx_count_r == 5'd0)
    else $error("receive count nonzero while idle");

  a_strobe_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.strobe |-> res_r.rdata == 32'd0)
    else $error("read data on a tick result");

  a_txd_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.txd |-> res_r.strobe)
    else $error("transmit bit without a bit step");

endmodule

[test/serial_port_shift_controller_check.sv]
// Checker for the serial port shift controller: tracks the register file, the bit
// divider and both shifters beat by beat and compares every result beat in order.
// Depends on spsc_pkg.
`timescale 1ns / 1ps

module serial_port_shift_controller_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_addr,
  input  logic [31:0] in_wdata,
  input  logic        in_rxd_in,
  input  logic        in_dsr_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_rdata,
  input  logic        out_txd_out,
  input  logic        out_bit_strobe,
  input  logic        out_dtr_port0,
  input  logic        out_dtr_port1,
  input  logic        out_irq_level,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          waiting,
  output int          checked,
  output int          strobes
);

  logic [7:0]  period_q;
  logic [31:0] tx_sh, rx_sh;
  logic [4:0]  tx_cnt, rx_cnt;
  logic        tx_busy, rx_busy, rx_full;
  logic [15:0] ctl, mode_r, baud_r;
  logic        dsr_last;
  logic [7:0]  divider;
  logic        irq;
  spsc_pkg::out_beat_t port_results_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t: beat %0d: %s", $realtime, checked, msg);
    fail_count++;
  endtask

  function automatic bit word_end(input logic [4:0] cnt);
    int len;
    len = (int'(ctl[spsc_pkg::CTL_LEN_HI -: 2]) + 1) * 8;
    return int'(cnt) + 1 >= len;
  endfunction

  task automatic clear_port();
    tx_sh = '0;
    rx_sh = '0;
    tx_cnt = '0;
    rx_cnt = '0;
    tx_busy = 1'b0;
    rx_busy = 1'b0;
    rx_full = 1'b0;
    ctl = '0;
    mode_r = '0;
    baud_r = '0;
  endtask

  task automatic shift_bit(input logic rxd, output logic txd);
    txd = 1'b0;
    if ((rx_busy && ctl[spsc_pkg::CTL_RX_EN]) || (tx_busy && ctl[spsc_pkg::CTL_TX_EN])) begin
      if (tx_busy) begin
        txd = tx_sh[tx_cnt];
        if (word_end(tx_cnt)) begin
          tx_cnt = '0;
          tx_busy = 1'b0;
          if (ctl[spsc_pkg::CTL_TX_IRQ]) irq = 1'b1;
        end else begin
          tx_cnt = tx_cnt + 5'd1;
        end
      end
      if (rx_busy) begin
        rx_sh[rx_cnt] = rxd;
        if (word_end(rx_cnt)) begin
          rx_cnt = '0;
          rx_busy = 1'b0;
          rx_full = 1'b1;
          if (ctl[spsc_pkg::CTL_RX_IRQ]) irq = 1'b1;
        end else begin
          rx_cnt = rx_cnt + 5'd1;
        end
      end
    end
  endtask

  task automatic advance_port(input spsc_pkg::in_beat_t b, output spsc_pkg::out_beat_t r);
    logic [8:0] sum;
    logic       txd;
    r = '0;
    case (b.kind)
      spsc_pkg::KIND_WRITE: begin
        case (b.addr)
          spsc_pkg::ADDR_DATA: begin
            tx_sh = b.wdata;
            tx_busy = 1'b1;
          end
          spsc_pkg::ADDR_MODE: mode_r = b.wdata[15:0];
          spsc_pkg::ADDR_CONTROL: begin
            ctl = b.wdata[15:0] & spsc_pkg::CTL_STORE_MASK;
            if (b.wdata[spsc_pkg::CTL_ACK]) irq = 1'b0;
            if (b.wdata[spsc_pkg::CTL_RESET]) begin
              irq = 1'b0;
              clear_port();
            end
          end
          spsc_pkg::ADDR_BAUD: baud_r = b.wdata[15:0];
          default: ;
        endcase
      end
      spsc_pkg::KIND_READ: begin
        case (b.addr)
          spsc_pkg::ADDR_DATA: begin
            r.rdata = rx_sh;
            rx_full = 1'b0;
            rx_busy = 1'b1;
          end
          spsc_pkg::ADDR_STATUS: r.rdata = {30'd0, rx_full, ~tx_busy};
          spsc_pkg::ADDR_MODE: r.rdata = {16'd0, mode_r};
          spsc_pkg::ADDR_CONTROL: r.rdata = {16'd0, ctl};
          spsc_pkg::ADDR_BAUD: r.rdata = {16'd0, baud_r};
          default: ;
        endcase
      end
      spsc_pkg::KIND_TICK: begin
        if (divider <= 8'd1) begin
          sum = {1'b0, divider} + {1'b0, period_q};
          divider = (sum == 9'd0) ? 8'd0 : 8'(sum - 9'd1);
          r.strobe = 1'b1;
          shift_bit(b.rxd, txd);
          r.txd = txd;
        end else begin
          divider = divider - 8'd1;
        end
        if (b.dsr && !dsr_last && ctl[spsc_pkg::CTL_DSR_IRQ]) irq = 1'b1;
        dsr_last = b.dsr;
      end
      default: ;
    endcase
    r.dtr0 = ctl[spsc_pkg::CTL_DTR] & ~ctl[spsc_pkg::CTL_PORT_SEL];
    r.dtr1 = ctl[spsc_pkg::CTL_DTR] & ctl[spsc_pkg::CTL_PORT_SEL];
    r.irq = irq;
  endtask

  always @(posedge clk) begin : watch
    spsc_pkg::in_beat_t  beat;
    spsc_pkg::out_beat_t want, got;
    if (!rst_n) begin
      period_q = spsc_pkg::PERIOD_RESET;
      clear_port();
      dsr_last = 1'b0;
      divider = '0;
      irq = 1'b0;
      port_results_q.delete();
      fail_count = 0;
      checked = 0;
      strobes = 0;
    end else begin
      if (cfg_we) period_q = cfg_wdata;
      if (out_valid && out_ready) begin
        got = {out_rdata, out_txd_out, out_bit_strobe, out_dtr_port0, out_dtr_port1,
               out_irq_level};
        if (port_results_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = port_results_q.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch($sformatf("rdata %h, want %h", got.rdata, want.rdata));
          if (got.txd !== want.txd)
            report_mismatch($sformatf("txd_out %b, want %b", got.txd, want.txd));
          if (got.strobe !== want.strobe)
            report_mismatch($sformatf("bit_strobe %b, want %b", got.strobe, want.strobe));
          if (got.dtr0 !== want.dtr0)
            report_mismatch($sformatf("dtr_port0 %b, want %b", got.dtr0, want.dtr0));
          if (got.dtr1 !== want.dtr1)
            report_mismatch($sformatf("dtr_port1 %b, want %b", got.dtr1, want.dtr1));
          if (got.irq !== want.irq)
            report_mismatch($sformatf("irq_level %b, want %b", got.irq, want.irq));
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        beat.kind = spsc_pkg::kind_t'(in_mode);
        beat.addr = in_addr;
        beat.wdata = in_wdata;
        beat.rxd = in_rxd_in;
        beat.dsr = in_dsr_in;
        advance_port(beat, want);
        if (want.strobe) strobes++;
        port_results_q.push_back(want);
      end
    end
    waiting = port_results_q.size();
  end

endmodule

[test/serial_port_shift_controller_test.sv]
// Top of the serial port shift controller testbench: clock, reset, bus and tick
// stimulus, bit period writes, receiver stalls and the verdict. Depends on
// spsc_pkg, the block and serial_port_shift_controller_check.
`timescale 1ns / 1ps

module serial_port_shift_controller_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [3:0]  in_addr = '0;
  logic [31:0] in_wdata = '0;
  logic        in_rxd_in = 1'b0;
  logic        in_dsr_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_rdata;
  logic        out_txd_out;
  logic        out_bit_strobe;
  logic        out_dtr_port0;
  logic        out_dtr_port1;
  logic        out_irq_level;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  int          fail_count;
  int          waiting;
  int          checked;
  int          strobes;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int beats_sent = 0;
  int period_writes = 0;

  serial_port_shift_controller uut (.*);
  serial_port_shift_controller_check check (.*);

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // hold off the receiver for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(input spsc_pkg::kind_t kind, input logic [3:0] addr,
                           input logic [31:0] wdata, input logic rxd, input logic dsr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= kind;
    in_addr <= addr;
    in_wdata <= wdata;
    in_rxd_in <= rxd;
    in_dsr_in <= dsr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic tick();
    send_beat(spsc_pkg::KIND_TICK, 4'($urandom), $urandom, 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic set_bit_period(input logic [7:0] value);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_writes++;
  endtask

  // control write, optional data load and receive arm, then mostly ticks
  task automatic run_session();
    logic [31:0] ctl_word;
    ctl_word = $urandom;
    ctl_word[spsc_pkg::CTL_TX_EN] = ($urandom_range(9) != 0);
    ctl_word[spsc_pkg::CTL_RX_EN] = ($urandom_range(9) != 0);
    ctl_word[spsc_pkg::CTL_RESET] = ($urandom_range(19) == 0);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_CONTROL, ctl_word,
              1'($urandom_range(1)), 1'($urandom_range(1)));
    if ($urandom_range(1))
      send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_DATA, $urandom, 1'b0, 1'b0);
    if ($urandom_range(1))
      send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_DATA, $urandom, 1'b0, 1'b0);
    repeat ($urandom_range(4, 40)) begin
      case ($urandom_range(19))
        0: send_beat(spsc_pkg::kind_t'($urandom_range(3)), 4'($urandom), $urandom,
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        1: send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_STATUS, $urandom, 1'b0, 1'b0);
        2: send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_DATA, $urandom, 1'b0, 1'b0);
        3: send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_DATA, $urandom, 1'b0, 1'b0);
        default: tick();
      endcase
    end
  endtask

  initial begin
    logic [31:0] ctl_word;
    int target;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_bit_period(8'd1);
    send_beat(spsc_pkg::KIND_TICK, spsc_pkg::ADDR_DATA, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_STATUS, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_DATA, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_CONTROL, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, 4'hF, '1, 1'b1, 1'b1);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_MODE, '1, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_MODE, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_BAUD, 32'h8000_7FFF, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_BAUD, '0, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_STATUS, '1, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_NOP, 4'hF, '1, 1'b1, 1'b1);
    ctl_word = '0;
    ctl_word[spsc_pkg::CTL_TX_EN] = 1'b1;
    ctl_word[spsc_pkg::CTL_RX_EN] = 1'b1;
    ctl_word[spsc_pkg::CTL_DTR] = 1'b1;
    ctl_word[spsc_pkg::CTL_TX_IRQ] = 1'b1;
    ctl_word[spsc_pkg::CTL_RX_IRQ] = 1'b1;
    ctl_word[spsc_pkg::CTL_DSR_IRQ] = 1'b1;
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_CONTROL, ctl_word, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_DATA, 32'hFFFF_FFA5, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_DATA, '0, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_beat(spsc_pkg::KIND_TICK, '0, '0, 1'($urandom_range(1)), i[0]);
    send_beat(spsc_pkg::KIND_READ, spsc_pkg::ADDR_STATUS, '0, 1'b0, 1'b0);
    ctl_word[spsc_pkg::CTL_ACK] = 1'b1;
    ctl_word[spsc_pkg::CTL_PORT_SEL] = 1'b1;
    ctl_word[spsc_pkg::CTL_LEN_HI -: 2] = 2'b11;
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_CONTROL, ctl_word, 1'b0, 1'b0);
    send_beat(spsc_pkg::KIND_WRITE, spsc_pkg::ADDR_CONTROL, '1, 1'b0, 1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_bit_period(8'd2);
        1: set_bit_period(8'($urandom_range(3, 9)));
        2: set_bit_period(8'd1);
        3: set_bit_period(8'd255);
        default: set_bit_period(spsc_pkg::PERIOD_RESET);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (p == 2) long_hold = 1'b1;
      target = beats_sent + 240;
      while (beats_sent < target) run_session();
    end

    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Run covered %0d input beats and %0d result beats, %0d of them bit steps,",
             beats_sent, checked, strobes);
    $display("over %0d bit period settings and four sender/receiver idling patterns.",
             period_writes);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[serial_port_shift_controller.f]
rtl/spsc_pkg.sv
rtl/serial_port_shift_controller.sv
test/serial_port_shift_controller_check.sv
test/serial_port_shift_controller_test.sv
